// ===== hdl/tga_pkg.sv =====
// Shared constants, result kinds and controller/datapath command and status types.
package tga_pkg;

	// Largest accepted image width or height.
	localparam int MAX_DIM_DEFAULT = 4096;

	// Width of the 16-bit header size fields.
	localparam int HDR_FIELD_W = 16;

	// Result kinds.
	localparam logic [2:0] KIND_PIXEL     = 3'd0;
	localparam logic [2:0] KIND_HDR_OK    = 3'd1;
	localparam logic [2:0] KIND_DONE      = 3'd2;
	localparam logic [2:0] KIND_SHORT     = 3'd3;
	localparam logic [2:0] KIND_BAD_SIZE  = 3'd4;
	localparam logic [2:0] KIND_BAD_DEPTH = 3'd5;
	localparam logic [2:0] KIND_BAD_TYPE  = 3'd6;

	// Byte offsets within the 18-byte header.
	localparam logic [4:0] HDR_ID_LEN    = 5'd0;
	localparam logic [4:0] HDR_IMG_TYPE  = 5'd2;
	localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
	localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
	localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
	localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
	localparam logic [4:0] HDR_DEPTH     = 5'd16;
	localparam logic [4:0] HDR_DESC      = 5'd17;

	// Header field values and bit positions.
	localparam logic [7:0] TYPE_RAW      = 8'd2;
	localparam logic [7:0] TYPE_RLE      = 8'd10;
	localparam logic [7:0] DEPTH_24      = 8'd24;
	localparam logic [7:0] DEPTH_32      = 8'd32;
	localparam int         DESC_TOP_DOWN = 5;
	localparam int         PKT_RUN_BIT   = 7;
	localparam logic [7:0] ALPHA_OPAQUE  = 8'hFF;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       byte_ready;
		logic       hdr_write;
		logic       hdr_accept;
		logic       id_dec;
		logic       pkt_load;
		logic       comp_write;
		logic       pix_emit;
		logic       adjust;
		logic       emit;
		logic [2:0] emit_kind;
		logic       emit_last;
		logic       clear;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       byte_taken;
		logic       eof;
		logic       byte_last;
		logic [2:0] hdr_kind;
		logic       id_one;
		logic       id_zero;
		logic       type_rle;
		logic       pkt_run;
		logic       pkt_le1;
		logic       comp_last;
		logic       img_done;
		logic       col_over;
		logic       out_free;
	} status_t;

endpackage

// ===== hdl/tga_ifs.sv =====
// Valid/ready channel interfaces for the file bytes and the decoded results.
interface tga_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_file;

	modport source(output valid, data_byte, end_of_file, input ready);
	modport sink(input valid, data_byte, end_of_file, output ready);
endinterface

interface tga_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [23:0] pixel_index;
	logic [11:0] dest_x;
	logic [11:0] dest_y;
	logic [7:0]  run_length;
	logic [7:0]  blue;
	logic [7:0]  green;
	logic [7:0]  red;
	logic [7:0]  alpha;
	logic [12:0] image_width;
	logic [12:0] image_height;
	logic        last;

	modport source(output valid, kind, pixel_index, dest_x, dest_y, run_length, blue, green,
		red, alpha, image_width, image_height, last, input ready);
	modport sink(input valid, kind, pixel_index, dest_x, dest_y, run_length, blue, green,
		red, alpha, image_width, image_height, last, output ready);
endinterface

// ===== hdl/tga_rle_image_decoder.sv =====
// Each byte is taken in the idle state, latched and decoded; the final byte of a pixel then
// passes the emit and advance states, with one row wrap per row boundary that its span crosses.
// Every byte ends in the end-of-file check, and only then is a new byte taken.
// A stalled result sink holds the sequencer before the next result is loaded.
// Reset (asynchronous, active low) and the end of each file return the parser to the header.
module tga_rle_image_decoder #(
	parameter int MAX_DIM = tga_pkg::MAX_DIM_DEFAULT
) (
	input logic          clk,
	input logic          arst_n,
	tga_byte_if.sink     file_bytes,
	tga_result_if.source results
);
	import tga_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequencer.
	tga_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	// Registers, counters and result register.
	tga_dp #(
		.MAX_DIM (MAX_DIM)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.file_bytes (file_bytes),
		.results    (results)
	);
endmodule

// ===== hdl/tga_dp.sv =====
// Datapath: header registers, packet and pixel counters, coordinates and the result register.
module tga_dp #(
	parameter int MAX_DIM = tga_pkg::MAX_DIM_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tga_pkg::cmd_t    cmd,
	output tga_pkg::status_t status,
	tga_byte_if.sink         file_bytes,
	tga_result_if.source     results
);
	import tga_pkg::*;

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int COL_W = $clog2(MAX_DIM + 128);
	localparam int PIX_W = $clog2(longint'(MAX_DIM) * longint'(MAX_DIM) + 1);
	localparam int REM_W = (PIX_W > 8) ? PIX_W : 8;

	typedef struct packed {
		logic [2:0]  kind;
		logic [23:0] pixel_index;
		logic [11:0] dest_x;
		logic [11:0] dest_y;
		logic [7:0]  run_length;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [7:0]  alpha;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic        last;
	} result_t;

	logic [7:0]              byte_q;
	logic                    eof_q;
	logic [4:0]              bc_q;
	logic [7:0]              id_len_q;
	logic [7:0]              img_type_q;
	logic [HDR_FIELD_W-1:0]  width_q;
	logic [HDR_FIELD_W-1:0]  height_q;
	logic [7:0]              depth_q;
	logic                    top_down_q;
	logic                    bpp4_q;
	logic [PIX_W-1:0]        total_q;
	logic [PIX_W-1:0]        pix_q;
	logic [COL_W-1:0]        col_q;
	logic [DIM_W-1:0]        row_q;
	logic [7:0]              pkt_left_q;
	logic                    pkt_run_q;
	logic [1:0]              comp_q;
	logic [7:0]              blue_q;
	logic [7:0]              green_q;
	logic [7:0]              red_q;
	logic                    out_valid_q;
	result_t                 res_q;

	logic                     byte_taken;
	logic                     out_free;
	logic                     size_bad;
	logic                     depth_bad;
	logic                     type_bad;
	logic [2:0]               hdr_kind;
	logic                     type_rle;
	logic                     comp_last;
	logic [2*HDR_FIELD_W-1:0] area;
	logic [REM_W-1:0]         remaining;
	logic [7:0]               run_cnt;
	logic [7:0]               span_cnt;
	logic [HDR_FIELD_W-1:0]   y_dest;
	result_t                  res_next;

	// Input handshake.
	assign file_bytes.ready = cmd.byte_ready;
	assign byte_taken       = file_bytes.valid & cmd.byte_ready;
	assign out_free         = !out_valid_q || results.ready;

	// Header checks in the order size, depth, type.
	assign size_bad  = (width_q == '0) || (height_q == '0) ||
		(width_q > HDR_FIELD_W'(MAX_DIM)) || (height_q > HDR_FIELD_W'(MAX_DIM));
	assign depth_bad = (depth_q != DEPTH_24) && (depth_q != DEPTH_32);
	assign type_bad  = (img_type_q != TYPE_RAW) && (img_type_q != TYPE_RLE);
	assign hdr_kind  = size_bad ? KIND_BAD_SIZE : depth_bad ? KIND_BAD_DEPTH :
		type_bad ? KIND_BAD_TYPE : KIND_HDR_OK;
	assign type_rle  = (img_type_q == TYPE_RLE);
	assign comp_last = (comp_q == (bpp4_q ? 2'd3 : 2'd2));
	assign area      = width_q * height_q;

	// Span length: a run packet is clipped to the pixels that remain.
	assign remaining = REM_W'(total_q) - REM_W'(pix_q);
	assign run_cnt   = (REM_W'(pkt_left_q) > remaining) ? remaining[7:0] : pkt_left_q;
	assign span_cnt  = (type_rle && pkt_run_q) ? run_cnt : 8'd1;

	// Destination row, flipped for bottom-up images.
	assign y_dest = top_down_q ? HDR_FIELD_W'(row_q) :
		height_q - HDR_FIELD_W'(1) - HDR_FIELD_W'(row_q);

	// Status back to the controller.
	assign status.byte_taken = byte_taken;
	assign status.eof        = eof_q;
	assign status.byte_last  = (bc_q == HDR_DESC);
	assign status.hdr_kind   = hdr_kind;
	assign status.id_one     = (id_len_q == 8'd1);
	assign status.id_zero    = (id_len_q == 8'd0);
	assign status.type_rle   = type_rle;
	assign status.pkt_run    = pkt_run_q;
	assign status.pkt_le1    = (pkt_left_q <= 8'd1);
	assign status.comp_last  = comp_last;
	assign status.img_done   = (pix_q >= total_q);
	assign status.col_over   = (col_q >= COL_W'(width_q));
	assign status.out_free   = out_free;

	// Latch the accepted byte.
	always_ff @(posedge clk) begin
		if (byte_taken) begin
			byte_q <= file_bytes.data_byte;
			eof_q  <= file_bytes.end_of_file;
		end
	end

	// Header, packet and position state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q       <= '0;
			id_len_q   <= '0;
			img_type_q <= '0;
			width_q    <= '0;
			height_q   <= '0;
			depth_q    <= '0;
			top_down_q <= 1'b0;
			bpp4_q     <= 1'b0;
			total_q    <= '0;
			pix_q      <= '0;
			col_q      <= '0;
			row_q      <= '0;
			pkt_left_q <= '0;
			pkt_run_q  <= 1'b0;
			comp_q     <= '0;
		end else if (cmd.clear) begin
			bc_q       <= '0;
			id_len_q   <= '0;
			img_type_q <= '0;
			width_q    <= '0;
			height_q   <= '0;
			depth_q    <= '0;
			top_down_q <= 1'b0;
			bpp4_q     <= 1'b0;
			total_q    <= '0;
			pix_q      <= '0;
			col_q      <= '0;
			row_q      <= '0;
			pkt_left_q <= '0;
			pkt_run_q  <= 1'b0;
			comp_q     <= '0;
		end else begin
			if (cmd.hdr_write) begin
				case (bc_q)
					HDR_ID_LEN:    id_len_q       <= byte_q;
					HDR_IMG_TYPE:  img_type_q     <= byte_q;
					HDR_WIDTH_LO:  width_q[7:0]   <= byte_q;
					HDR_WIDTH_HI:  width_q[15:8]  <= byte_q;
					HDR_HEIGHT_LO: height_q[7:0]  <= byte_q;
					HDR_HEIGHT_HI: height_q[15:8] <= byte_q;
					HDR_DEPTH:     depth_q        <= byte_q;
					HDR_DESC:      top_down_q     <= byte_q[DESC_TOP_DOWN];
					default: begin
					end
				endcase
				if (bc_q != HDR_DESC) begin
					bc_q <= bc_q + 5'd1;
				end
			end
			if (cmd.hdr_accept) begin
				bpp4_q  <= (depth_q == DEPTH_32);
				total_q <= PIX_W'(area);
				pix_q   <= '0;
				col_q   <= '0;
				row_q   <= '0;
			end
			if (cmd.id_dec && (id_len_q != 8'd0)) begin
				id_len_q <= id_len_q - 8'd1;
			end
			if (cmd.pkt_load) begin
				pkt_left_q <= {1'b0, byte_q[6:0]} + 8'd1;
				pkt_run_q  <= byte_q[PKT_RUN_BIT];
				comp_q     <= '0;
			end
			if (cmd.comp_write) begin
				comp_q <= comp_last ? 2'd0 : comp_q + 2'd1;
			end
			if (cmd.pix_emit) begin
				pix_q <= pix_q + PIX_W'(span_cnt);
				col_q <= col_q + COL_W'(span_cnt);
				if (type_rle) begin
					if (pkt_run_q) begin
						pkt_left_q <= '0;
					end else if (pkt_left_q != 8'd0) begin
						pkt_left_q <= pkt_left_q - 8'd1;
					end
				end
			end
			// One row wrap per cycle after a span moves the column past the width.
			if (cmd.adjust) begin
				col_q <= col_q - COL_W'(width_q);
				row_q <= row_q + DIM_W'(1);
			end
		end
	end

	// Colour components of the pixel being assembled.
	always_ff @(posedge clk) begin
		if (cmd.comp_write) begin
			case (comp_q)
				2'd0:    blue_q  <= byte_q;
				2'd1:    green_q <= byte_q;
				2'd2:    red_q   <= byte_q;
				default: begin
				end
			endcase
		end
	end

	// Next result: fields that do not apply to the kind stay zero.
	always_comb begin
		res_next = '0;
		if (cmd.pix_emit) begin
			res_next.kind        = KIND_PIXEL;
			res_next.pixel_index = 24'(pix_q);
			res_next.dest_x      = 12'(col_q);
			res_next.dest_y      = y_dest[11:0];
			res_next.run_length  = span_cnt;
			res_next.blue        = blue_q;
			res_next.green       = green_q;
			res_next.red         = red_q;
			res_next.alpha       = bpp4_q ? byte_q : ALPHA_OPAQUE;
		end else begin
			res_next.kind = cmd.emit_kind;
			res_next.last = cmd.emit_last;
			if (cmd.emit_kind == KIND_HDR_OK) begin
				res_next.image_width  = 13'(width_q);
				res_next.image_height = 13'(height_q);
			end
		end
	end

	// Result register towards the sink.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.pix_emit) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit || cmd.pix_emit) begin
			res_q <= res_next;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.kind         = res_q.kind;
	assign results.pixel_index  = res_q.pixel_index;
	assign results.dest_x       = res_q.dest_x;
	assign results.dest_y       = res_q.dest_y;
	assign results.run_length   = res_q.run_length;
	assign results.blue         = res_q.blue;
	assign results.green        = res_q.green;
	assign results.red          = res_q.red;
	assign results.alpha        = res_q.alpha;
	assign results.image_width  = res_q.image_width;
	assign results.image_height = res_q.image_height;
	assign results.last         = res_q.last;

	// A result is only loaded into a free result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.pix_emit) |-> out_free)
		else $error("result loaded over a pending result");

	// Row wrapping has finished before the next span is emitted.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pix_emit |-> (17'(col_q) < 17'(width_q)))
		else $error("span emitted with column beyond width");

	// An accepted header always gives a non-empty image.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hdr_accept |=> (total_q != '0))
		else $error("accepted header with zero pixel total");
endmodule

// ===== hdl/tga_ctrl.sv =====
// Controller: file phase and per-byte sequencing of the datapath.
module tga_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  tga_pkg::status_t status,
	output tga_pkg::cmd_t    cmd
);
	import tga_pkg::*;

	// Sequencer states.
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DECODE   = 3'd1;
	localparam logic [2:0] S_EMIT_PIX = 3'd2;
	localparam logic [2:0] S_ADVANCE  = 3'd3;
	localparam logic [2:0] S_EOF      = 3'd4;

	// File phases.
	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_IDSKIP = 3'd1;
	localparam logic [2:0] PH_PACKET = 3'd2;
	localparam logic [2:0] PH_PIXEL  = 3'd3;
	localparam logic [2:0] PH_WAIT   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [2:0] phase_q;
	logic [2:0] phase_d;
	logic [2:0] ph_body;
	logic [2:0] ph_after_hdr;

	// Phase that follows the header or the ID field.
	assign ph_body      = status.type_rle ? PH_PACKET : PH_PIXEL;
	assign ph_after_hdr = status.id_zero ? ph_body : PH_IDSKIP;

	// Next state and commands.
	always_comb begin
		cmd            = '0;
		state_d        = state_q;
		phase_d        = phase_q;
		cmd.byte_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (status.byte_taken) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (status.out_free) begin
					state_d = S_EOF;
					unique case (phase_q)
						PH_HEADER: begin
							cmd.hdr_write = 1'b1;
							if (status.byte_last) begin
								cmd.emit      = 1'b1;
								cmd.emit_kind = status.hdr_kind;
								if (status.hdr_kind == KIND_HDR_OK) begin
									cmd.hdr_accept = 1'b1;
									phase_d        = ph_after_hdr;
								end else begin
									cmd.emit_last = 1'b1;
									phase_d       = PH_WAIT;
								end
							end
						end
						PH_IDSKIP: begin
							cmd.id_dec = 1'b1;
							if (status.id_one || status.id_zero) begin
								phase_d = ph_body;
							end
						end
						PH_PACKET: begin
							cmd.pkt_load = 1'b1;
							phase_d      = PH_PIXEL;
						end
						PH_PIXEL: begin
							cmd.comp_write = 1'b1;
							if (status.comp_last) begin
								state_d = S_EMIT_PIX;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_EMIT_PIX: begin
				if (status.out_free) begin
					cmd.pix_emit = 1'b1;
					state_d      = S_ADVANCE;
					if (status.type_rle) begin
						if (status.pkt_run || status.pkt_le1) begin
							phase_d = PH_PACKET;
						end else begin
							phase_d = PH_PIXEL;
						end
					end
				end
			end
			S_ADVANCE: begin
				if (status.img_done) begin
					if (status.out_free) begin
						cmd.emit      = 1'b1;
						cmd.emit_kind = KIND_DONE;
						cmd.emit_last = 1'b1;
						phase_d       = PH_WAIT;
						state_d       = S_EOF;
					end
				end else if (status.col_over) begin
					cmd.adjust = 1'b1;
				end else begin
					state_d = S_EOF;
				end
			end
			S_EOF: begin
				if (!status.eof) begin
					state_d = S_IDLE;
				end else if (phase_q == PH_WAIT) begin
					cmd.clear = 1'b1;
					phase_d   = PH_HEADER;
					state_d   = S_IDLE;
				end else if (status.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = (phase_q == PH_HEADER) ? KIND_SHORT : KIND_DONE;
					cmd.emit_last = 1'b1;
					cmd.clear     = 1'b1;
					phase_d       = PH_HEADER;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_HEADER;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	// The end of a file always brings the parser back to the header.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (phase_q == PH_HEADER))
		else $error("phase not back at header after end of file");

	// An accepted header always leaves the header phase.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hdr_accept |=> (phase_q != PH_HEADER))
		else $error("still in header phase after header accepted");

	// A span is emitted only once its final component byte has been decoded.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pix_emit |-> ($past(state_q) == S_DECODE || $past(state_q) == S_EMIT_PIX))
		else $error("span emitted out of sequence");
endmodule

// ===== sim/tb_tga_rle_image_decoder.sv =====
// Self-checking testbench for the TGA decoder: byte stream in, predicted spans and status out.
`timescale 1ns / 1ps

module tb_tga_rle_image_decoder;
	import tga_pkg::*;

	localparam int QUIET_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_BYTES = 80;

	typedef enum logic [2:0] {
		DEC_HEADER,
		DEC_ID_SKIP,
		DEC_PACKET,
		DEC_PIXEL,
		DEC_WAIT
	} dec_state_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eof;
	} file_byte_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [23:0] pixel_index;
		logic [11:0] dest_x;
		logic [11:0] dest_y;
		logic [7:0]  run_length;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [7:0]  alpha;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic        last;
	} tga_result_t;

	logic clk;
	logic arst_n;

	tga_byte_if   byte_ch();
	tga_result_if result_ch();

	tga_rle_image_decoder u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.file_bytes (byte_ch),
		.results    (result_ch)
	);

	// Stimulus and scoreboard storage.
	logic [7:0]  file_buf[$];
	file_byte_t  file_bytes_q[$];
	tga_result_t expected_results[$];
	tga_result_t seen_result;
	tga_result_t due_result;

	int          total_bytes;
	int          bytes_taken;
	int          results_seen;
	int          mismatches;
	int          quiet_cycles;
	int          hold_left;
	bit          hold_done;
	logic [1:0]  stage;
	int          send_idle_pct[3] = '{27, 63, 0};
	int          recv_idle_pct[3] = '{63, 27, 0};

	// Decoder state mirrored by the predictor.
	dec_state_t  dec_state;
	logic [4:0]  hdr_pos;
	logic [7:0]  id_left;
	logic [7:0]  img_type;
	logic [15:0] img_w;
	logic [15:0] img_h;
	logic [7:0]  depth_val;
	logic        four_bytes;
	logic        top_down;
	longint      pix_done;
	logic [7:0]  pkt_left;
	logic        pkt_run;
	int          comp_idx;
	logic [23:0] colour;

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] seen,
		input logic [31:0] due);
		if (seen !== due)
			report_mismatch($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
				results_seen, name, seen, due));
	endtask

	function automatic tga_result_t blank_result(input logic [2:0] kind, input logic last);
		tga_result_t r;
		r = '0;
		r.kind = kind;
		r.last = last;
		return r;
	endfunction

	function automatic dec_state_t data_start_state();
		if (id_left != 0)
			return DEC_ID_SKIP;
		return (img_type == TYPE_RLE) ? DEC_PACKET : DEC_PIXEL;
	endfunction

	function automatic longint image_pixels();
		return longint'(img_w) * longint'(img_h);
	endfunction

	task automatic reset_decoder();
		dec_state  = DEC_HEADER;
		hdr_pos    = '0;
		id_left    = '0;
		img_type   = '0;
		img_w      = '0;
		img_h      = '0;
		depth_val  = '0;
		four_bytes = 1'b0;
		top_down   = 1'b0;
		pix_done   = 0;
		pkt_left   = '0;
		pkt_run    = 1'b0;
		comp_idx   = 0;
		colour     = '0;
	endtask

	// One span starting at the current source index; closes the image when it is full.
	task automatic emit_span(input longint count, input logic [7:0] a);
		longint      w;
		longint      row;
		longint      col;
		longint      y;
		tga_result_t r;
		w   = (img_w != 0) ? longint'(img_w) : 1;
		row = pix_done / w;
		col = pix_done % w;
		y   = top_down ? row : (longint'(img_h) - 1 - row);
		r = blank_result(KIND_PIXEL, 1'b0);
		r.pixel_index = pix_done[23:0];
		r.dest_x      = col[11:0];
		r.dest_y      = y[11:0];
		r.run_length  = count[7:0];
		r.blue        = colour[7:0];
		r.green       = colour[15:8];
		r.red         = colour[23:16];
		r.alpha       = a;
		expected_results.push_back(r);
		pix_done += count;
		if (pix_done >= image_pixels()) begin
			expected_results.push_back(blank_result(KIND_DONE, 1'b1));
			dec_state = DEC_WAIT;
		end
	endtask

	// Advances the decoder by one file byte and queues the results it causes.
	task automatic decode_byte(input logic [7:0] b, input logic eof);
		logic [2:0]  verdict;
		tga_result_t r;
		int          n_comp;
		logic [7:0]  a;
		longint      span;
		case (dec_state)
			DEC_HEADER: begin
				case (hdr_pos)
					HDR_ID_LEN:    id_left = b;
					HDR_IMG_TYPE:  img_type = b;
					HDR_WIDTH_LO:  img_w[7:0] = b;
					HDR_WIDTH_HI:  img_w[15:8] = b;
					HDR_HEIGHT_LO: img_h[7:0] = b;
					HDR_HEIGHT_HI: img_h[15:8] = b;
					HDR_DEPTH:     depth_val = b;
					HDR_DESC:      top_down = b[DESC_TOP_DOWN];
					default: ;
				endcase
				if (hdr_pos < HDR_DESC) begin
					hdr_pos++;
				end else begin
					// Size is checked first, then depth, then type.
					if (img_w == 0 || img_h == 0 || img_w > MAX_DIM_DEFAULT ||
						img_h > MAX_DIM_DEFAULT)
						verdict = KIND_BAD_SIZE;
					else if (depth_val != DEPTH_24 && depth_val != DEPTH_32)
						verdict = KIND_BAD_DEPTH;
					else if (img_type != TYPE_RAW && img_type != TYPE_RLE)
						verdict = KIND_BAD_TYPE;
					else
						verdict = KIND_HDR_OK;
					if (verdict != KIND_HDR_OK) begin
						expected_results.push_back(blank_result(verdict, 1'b1));
						dec_state = DEC_WAIT;
					end else begin
						r = blank_result(KIND_HDR_OK, 1'b0);
						r.image_width  = img_w[12:0];
						r.image_height = img_h[12:0];
						expected_results.push_back(r);
						four_bytes = (depth_val == DEPTH_32);
						dec_state  = data_start_state();
					end
				end
			end
			DEC_ID_SKIP: begin
				if (id_left != 0)
					id_left--;
				if (id_left == 0)
					dec_state = data_start_state();
			end
			DEC_PACKET: begin
				pkt_left  = {1'b0, b[6:0]} + 8'd1;
				pkt_run   = b[PKT_RUN_BIT];
				comp_idx  = 0;
				dec_state = DEC_PIXEL;
			end
			DEC_PIXEL: begin
				n_comp = four_bytes ? 4 : 3;
				if (comp_idx < 3)
					colour[8*comp_idx +: 8] = b;
				if (comp_idx + 1 < n_comp) begin
					comp_idx++;
				end else begin
					comp_idx = 0;
					a = four_bytes ? b : ALPHA_OPAQUE;
					if (img_type == TYPE_RLE) begin
						if (pkt_run) begin
							// A run never reaches past the last pixel of the image.
							span = image_pixels() - pix_done;
							if (longint'(pkt_left) < span)
								span = pkt_left;
							pkt_left  = '0;
							dec_state = DEC_PACKET;
							emit_span(span, a);
						end else begin
							if (pkt_left != 0)
								pkt_left--;
							dec_state = (pkt_left != 0) ? DEC_PIXEL : DEC_PACKET;
							emit_span(1, a);
						end
					end else begin
						emit_span(1, a);
					end
				end
			end
			default: ;
		endcase
		// The end of the file closes whatever is still open and starts afresh.
		if (eof) begin
			if (dec_state == DEC_HEADER)
				expected_results.push_back(blank_result(KIND_SHORT, 1'b1));
			else if (dec_state != DEC_WAIT)
				expected_results.push_back(blank_result(KIND_DONE, 1'b1));
			reset_decoder();
		end
	endtask

	// File building.
	task automatic add_header(input logic [7:0] id_len, input logic [7:0] itype,
		input logic [15:0] w, input logic [15:0] h, input logic [7:0] depth,
		input logic [7:0] desc);
		file_buf.push_back(id_len);
		file_buf.push_back(8'($urandom));
		file_buf.push_back(itype);
		repeat (9)
			file_buf.push_back(8'($urandom));
		file_buf.push_back(w[7:0]);
		file_buf.push_back(w[15:8]);
		file_buf.push_back(h[7:0]);
		file_buf.push_back(h[15:8]);
		file_buf.push_back(depth);
		file_buf.push_back(desc);
	endtask

	task automatic add_pixel(input bit four);
		repeat (four ? 4 : 3)
			file_buf.push_back(8'($urandom));
	endtask

	task automatic add_random(input int count);
		repeat (count)
			file_buf.push_back(8'($urandom));
	endtask

	// Pixel data for a whole image; RLE images mix run and literal packets, or use only full runs when big.
	task automatic add_image(input longint w, input longint h, input bit four,
		input bit rle, input bit big);
		longint left;
		int     n;
		left = w * h;
		if (!rle) begin
			for (longint i = 0; i < left; i++)
				add_pixel(four);
		end else begin
			while (left > 0) begin
				if (big || $urandom_range(1)) begin
					if (big)
						n = 128;
					else if ($urandom_range(7) == 0)
						n = $urandom_range(128, 1);
					else
						n = $urandom_range(3, 1);
					file_buf.push_back((8'd1 << PKT_RUN_BIT) | 8'(n - 1));
					add_pixel(four);
				end else begin
					n = $urandom_range(4, 1);
					file_buf.push_back(8'(n - 1));
					repeat (n)
						add_pixel(four);
				end
				left -= n;
			end
		end
	endtask

	// Moves the file into the request queue, optionally cut short at a random byte.
	task automatic close_file(input bit cut);
		int keep;
		keep = file_buf.size();
		if (cut && keep > 1)
			keep = $urandom_range(keep - 1, 1);
		for (int i = 0; i < keep; i++)
			file_bytes_q.push_back('{data: file_buf[i], eof: (i == keep - 1)});
		file_buf.delete();
	endtask

	function automatic logic [15:0] pick_dim();
		case ($urandom_range(4))
			0: return 16'd0;
			1: return 16'(MAX_DIM_DEFAULT + 1);
			2: return 16'($urandom);
			3: return 16'(MAX_DIM_DEFAULT);
			default: return 16'($urandom_range(4, 1));
		endcase
	endfunction

	task automatic build_directed();
		// A one-byte file ends inside the header.
		file_buf.push_back(8'hFF);
		close_file(1'b0);
		// Size failures: zero width, one over the limit, and the largest field value.
		add_header(8'd0, TYPE_RAW, 16'd0, 16'd5, DEPTH_24, 8'h00);
		add_random(1);
		close_file(1'b0);
		add_header(8'd0, TYPE_RLE, 16'(MAX_DIM_DEFAULT + 1), 16'd1, DEPTH_32, 8'h00);
		close_file(1'b0);
		add_header(8'd0, TYPE_RAW, 16'd1, 16'hFFFF, DEPTH_24, 8'h00);
		close_file(1'b0);
		// Depth is reported ahead of type when both are wrong; then type alone.
		add_header(8'd0, 8'd3, 16'd2, 16'd2, 8'd16, 8'h00);
		add_random(2);
		close_file(1'b0);
		add_header(8'd0, 8'd3, 16'd2, 16'd2, DEPTH_32, 8'h00);
		close_file(1'b0);
		// A valid header that is the whole file.
		add_header(8'd0, TYPE_RAW, 16'd3, 16'd3, DEPTH_24, 8'hFF);
		close_file(1'b0);
		// Raw bottom-up image with an ID field and bytes after the last pixel.
		add_header(8'd2, TYPE_RAW, 16'd2, 16'd2, DEPTH_24, 8'h00);
		add_random(2);
		add_image(2, 2, 1'b0, 1'b0, 1'b0);
		add_random(2);
		close_file(1'b0);
		// A full-length run clipped to the pixels that remain.
		add_header(8'd0, TYPE_RLE, 16'd3, 16'd2, DEPTH_32, 8'h20);
		file_buf.push_back(8'hFF);
		add_pixel(1'b1);
		add_random(3);
		close_file(1'b0);
		// Literal and run packets, then a pixel cut off by the end of the file.
		add_header(8'd0, TYPE_RLE, 16'd3, 16'd2, DEPTH_24, 8'h00);
		file_buf.push_back(8'h01);
		add_pixel(1'b0);
		add_pixel(1'b0);
		file_buf.push_back(8'h81);
		add_pixel(1'b0);
		file_buf.push_back(8'h01);
		add_pixel(1'b0);
		add_random(2);
		close_file(1'b0);
		// The file ends while the ID field is being skipped.
		add_header(8'd5, TYPE_RAW, 16'd2, 16'd2, DEPTH_24, 8'h00);
		add_random(2);
		close_file(1'b0);
		// Longest ID field; the file ends on the byte that completes the image.
		add_header(8'd255, TYPE_RAW, 16'd1, 16'd1, DEPTH_32, 8'h20);
		add_random(255);
		add_pixel(1'b1);
		close_file(1'b0);
		// Widest and tallest images, built from full runs.
		add_header(8'd0, TYPE_RLE, 16'(MAX_DIM_DEFAULT), 16'd1, DEPTH_32, 8'h20);
		add_image(MAX_DIM_DEFAULT, 1, 1'b1, 1'b1, 1'b1);
		close_file(1'b0);
		add_header(8'd0, TYPE_RLE, 16'd1, 16'(MAX_DIM_DEFAULT), DEPTH_24, 8'h00);
		add_image(1, MAX_DIM_DEFAULT, 1'b0, 1'b1, 1'b1);
		close_file(1'b0);
	endtask

	task automatic build_random();
		int         start;
		int         pick;
		bit         four;
		bit         rle;
		bit         big;
		logic [7:0] id_len;
		logic [7:0] depth;
		logic [7:0] itype;
		logic [15:0] w;
		logic [15:0] h;
		start = file_bytes_q.size();
		while (file_bytes_q.size() - start < RANDOM_BYTES) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				// Well-formed file with random content.
				four   = $urandom_range(1);
				rle    = $urandom_range(1);
				big    = rle && ($urandom_range(14) == 0);
				id_len = ($urandom_range(3) == 0) ? 8'($urandom_range(6, 1)) : 8'd0;
				if (big && $urandom_range(1)) begin
					w = 16'(MAX_DIM_DEFAULT);
					h = 16'd1;
				end else if (big) begin
					w = 16'd1;
					h = 16'(MAX_DIM_DEFAULT);
				end else begin
					w = 16'($urandom_range(5, 1));
					h = 16'($urandom_range(4, 1));
				end
				add_header(id_len, rle ? TYPE_RLE : TYPE_RAW, w, h,
					four ? DEPTH_32 : DEPTH_24, 8'($urandom));
				add_random(id_len);
				add_image(w, h, four, rle, big);
				add_random($urandom_range(2));
				close_file($urandom_range(7) == 0);
			end else if (pick < 85) begin
				// Header with fields drawn from the edges and from noise.
				case ($urandom_range(2))
					0: depth = DEPTH_24;
					1: depth = DEPTH_32;
					default: depth = 8'($urandom);
				endcase
				case ($urandom_range(2))
					0: itype = TYPE_RAW;
					1: itype = TYPE_RLE;
					default: itype = 8'($urandom);
				endcase
				add_header(8'($urandom_range(3)), itype, pick_dim(), pick_dim(), depth,
					8'($urandom));
				add_random($urandom_range(6));
				close_file($urandom_range(3) == 0);
			end else begin
				// Plain noise, mostly shorter than a header.
				add_random($urandom_range(25, 1));
				close_file(1'b0);
			end
		end
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Byte driver: offers the head of the queue and decodes it once it is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_ch.valid && byte_ch.ready) begin
				decode_byte(byte_ch.data_byte, byte_ch.end_of_file);
				void'(file_bytes_q.pop_front());
				bytes_taken++;
				if (bytes_taken * 3 >= 2 * total_bytes)
					stage <= 2'd2;
				else if (bytes_taken * 3 >= total_bytes)
					stage <= 2'd1;
			end
			if (!byte_ch.valid || byte_ch.ready) begin
				if (file_bytes_q.size() != 0 &&
					$urandom_range(99) >= send_idle_pct[stage]) begin
					byte_ch.valid       <= 1'b1;
					byte_ch.data_byte   <= file_bytes_q[0].data;
					byte_ch.end_of_file <= file_bytes_q[0].eof;
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares each accepted result with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				seen_result.kind         = result_ch.kind;
				seen_result.pixel_index  = result_ch.pixel_index;
				seen_result.dest_x       = result_ch.dest_x;
				seen_result.dest_y       = result_ch.dest_y;
				seen_result.run_length   = result_ch.run_length;
				seen_result.blue         = result_ch.blue;
				seen_result.green        = result_ch.green;
				seen_result.red          = result_ch.red;
				seen_result.alpha        = result_ch.alpha;
				seen_result.image_width  = result_ch.image_width;
				seen_result.image_height = result_ch.image_height;
				seen_result.last         = result_ch.last;
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result %0d of kind %0d was not expected",
						results_seen, seen_result.kind));
				end else begin
					due_result = expected_results.pop_front();
					check_field("kind", seen_result.kind, due_result.kind);
					check_field("pixel_index", seen_result.pixel_index,
						due_result.pixel_index);
					check_field("dest_x", seen_result.dest_x, due_result.dest_x);
					check_field("dest_y", seen_result.dest_y, due_result.dest_y);
					check_field("run_length", seen_result.run_length, due_result.run_length);
					check_field("blue", seen_result.blue, due_result.blue);
					check_field("green", seen_result.green, due_result.green);
					check_field("red", seen_result.red, due_result.red);
					check_field("alpha", seen_result.alpha, due_result.alpha);
					check_field("image_width", seen_result.image_width,
						due_result.image_width);
					check_field("image_height", seen_result.image_height,
						due_result.image_height);
					check_field("last", seen_result.last, due_result.last);
				end
				results_seen++;
			end
			// One long hold-off at the start of the last third, so the decoder backs up.
			if (!hold_done && stage == 2'd2) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_idle_pct[stage]);
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a request.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("Simulation FAILED");
					$finish;
				end
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		arst_n              = 1'b0;
		byte_ch.valid       = 1'b0;
		byte_ch.data_byte   = '0;
		byte_ch.end_of_file = 1'b0;
		result_ch.ready     = 1'b0;
		stage               = 2'd0;
		bytes_taken         = 0;
		results_seen        = 0;
		mismatches          = 0;
		quiet_cycles        = 0;
		hold_left           = 0;
		hold_done           = 1'b0;
		reset_decoder();
		build_directed();
		build_random();
		total_bytes = file_bytes_q.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (file_bytes_q.size() != 0 || byte_ch.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				expected_results.size()));
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== tga_rle_image_decoder.f =====
hdl/tga_pkg.sv
hdl/tga_ifs.sv
hdl/tga_dp.sv
hdl/tga_ctrl.sv
hdl/tga_rle_image_decoder.sv
sim/tb_tga_rle_image_decoder.sv
